[rtl/rlc_pkg.sv]
package rlc_pkg;

  localparam int MAX_CLUSTERS = 32;
  localparam int COORD_BITS   = 20;

  localparam int RADIUS_BITS  = 43;
  localparam int COUNT_BITS   = 16;
  localparam int RES_IDX_W    = 5;

  localparam int CL_IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int USED_W   = $clog2(MAX_CLUSTERS + 1);
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int SUM_W    = SQ_W + 1;
  localparam int CMP_W    = (SUM_W > RADIUS_BITS) ? SUM_W : RADIUS_BITS;
  localparam int LEADER_W = 2 * COORD_BITS;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(4194304);
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;

  typedef struct packed {
    logic                         start_cloud;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } rlc_point_t;

  typedef struct packed {
    logic [RES_IDX_W-1:0]  cluster_index;
    logic                  new_cluster;
    logic [COUNT_BITS-1:0] member_count;
    logic                  table_full;
    logic                  last_result;
  } rlc_result_t;

  typedef struct packed {
    logic load;
    logic sq_x;
    logic sq_y;
  } rlc_dist_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DX,
    ST_MX,
    ST_MY,
    ST_CMP,
    ST_HIT,
    ST_END
  } rlc_state_t;

endpackage

[rtl/radius_leader_clustering.sv]
// Fixed-radius leader clustering. Each point item is checked against the leaders
// of the open clusters in index order; one result item goes out per cluster whose
// squared distance is below radius_squared, else the point opens a new cluster,
// or a table_full result is given when all entries are taken. last_result marks
// the final result of a point. Per open cluster an item takes one registered
// leader-memory read, one difference step, two passes through the one shared
// squarer and a compare, and one more step per match. point_stall is high while
// an item is in work. radius_squared is written only while idle.
module radius_leader_clustering
  import rlc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   point_valid,
  output logic                   point_stall,
  input  rlc_point_t             point,
  output logic                   result_valid,
  input  logic                   result_stall,
  output rlc_result_t            result,
  input  logic                   radius_valid,
  output logic                   radius_ready,
  input  logic [RADIUS_BITS-1:0] radius_squared
);

  rlc_state_t state, state_next;

  logic [USED_W-1:0]            j;
  logic [USED_W-1:0]            used;
  logic [USED_W-1:0]            used_start;
  logic [USED_W-1:0]            j_inc;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic [RADIUS_BITS-1:0]       radius;
  logic                         pend_valid;
  logic [CL_IDX_W-1:0]          pend_idx;
  logic [COUNT_BITS-1:0]        pend_cnt;
  logic [COUNT_BITS-1:0]        cnt;
  logic [COUNT_BITS-1:0]        cnt_sat;

  logic                         accept;
  logic                         slot_free;
  logic                         hit;
  rlc_dist_ctrl_t               dctrl;
  logic                         emit;
  rlc_result_t                  emit_item;
  logic                         adv;
  logic                         take_hit;
  logic                         open_new;

  logic                         lw_en;
  logic [LEADER_W-1:0]          leader_rd;
  logic                         cw_en;
  logic [CL_IDX_W-1:0]          cw_addr;
  logic [COUNT_BITS-1:0]        cw_data;
  logic [COUNT_BITS-1:0]        cnt_rd;

  assign accept       = point_valid && !point_stall;
  assign point_stall  = (state != ST_IDLE);
  assign radius_ready = (state == ST_IDLE);
  assign slot_free    = !result_valid || !result_stall;
  assign used_start   = point.start_cloud ? '0 : used;
  assign j_inc        = j + USED_W'(1);
  assign cnt_sat      = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_BITS'(1);

  always_comb begin
    state_next = state;
    dctrl      = '0;
    emit       = 1'b0;
    emit_item  = '0;
    adv        = 1'b0;
    take_hit   = 1'b0;
    open_new   = 1'b0;
    lw_en      = 1'b0;
    cw_en      = 1'b0;
    cw_addr    = j[CL_IDX_W-1:0];
    cw_data    = cnt_sat;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (used_start == '0) ? ST_END : ST_READ;
        end
      end
      ST_READ: state_next = ST_DX;
      ST_DX: begin
        dctrl.load = 1'b1;
        state_next = ST_MX;
      end
      ST_MX: begin
        dctrl.sq_x = 1'b1;
        state_next = ST_MY;
      end
      ST_MY: begin
        dctrl.sq_y = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (hit) begin
          state_next = ST_HIT;
        end else begin
          adv        = 1'b1;
          state_next = (j_inc == used) ? ST_END : ST_READ;
        end
      end
      ST_HIT: begin
        if (!pend_valid || slot_free) begin
          take_hit   = 1'b1;
          cw_en      = 1'b1;
          adv        = 1'b1;
          emit       = pend_valid;
          emit_item.cluster_index = RES_IDX_W'(pend_idx);
          emit_item.member_count  = pend_cnt;
          state_next = (j_inc == used) ? ST_END : ST_READ;
        end
      end
      ST_END: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          emit_item.last_result = 1'b1;
          if (pend_valid) begin
            emit_item.cluster_index = RES_IDX_W'(pend_idx);
            emit_item.member_count  = pend_cnt;
          end else if (used < USED_W'(MAX_CLUSTERS)) begin
            open_new = 1'b1;
            lw_en    = 1'b1;
            cw_en    = 1'b1;
            cw_addr  = used[CL_IDX_W-1:0];
            cw_data  = COUNT_BITS'(1);
            emit_item.cluster_index = RES_IDX_W'(used);
            emit_item.new_cluster   = 1'b1;
            emit_item.member_count  = COUNT_BITS'(1);
          end else begin
            emit_item.table_full = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      j            <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      radius       <= RADIUS_RESET;
    end else begin
      if (radius_valid && radius_ready) begin
        radius <= radius_squared;
      end
      if (accept) begin
        used       <= used_start;
        j          <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (adv) begin
          j <= j_inc;
        end
        if (take_hit) begin
          pend_valid <= 1'b1;
        end
        if (open_new) begin
          used <= used + USED_W'(1);
        end
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= point.point_x;
      py <= point.point_y;
    end
    if (state == ST_DX) begin
      cnt <= cnt_rd;
    end
    if (take_hit) begin
      pend_idx <= j[CL_IDX_W-1:0];
      pend_cnt <= cnt_sat;
    end
    if (emit) begin
      result <= emit_item;
    end
  end

  rlc_ram #(
    .WIDTH (LEADER_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_leader_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (used[CL_IDX_W-1:0]),
    .wdata ({py, px}),
    .raddr (j[CL_IDX_W-1:0]),
    .rdata (leader_rd)
  );

  rlc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_CLUSTERS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .raddr (j[CL_IDX_W-1:0]),
    .rdata (cnt_rd)
  );

  rlc_dist u_dist (
    .clk    (clk),
    .ctrl   (dctrl),
    .px     (px),
    .py     (py),
    .leader (leader_rd),
    .radius (radius),
    .hit    (hit)
  );

endmodule

[rtl/rlc_ram.sv]
module rlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rlc_dist.sv]
module rlc_dist
  import rlc_pkg::*;
(
  input  logic                         clk,
  input  rlc_dist_ctrl_t               ctrl,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic [LEADER_W-1:0]          leader,
  input  logic [RADIUS_BITS-1:0]       radius,
  output logic                         hit
);

  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic signed [COORD_BITS:0] abs_x;
  logic signed [COORD_BITS:0] abs_y;
  logic [COORD_BITS-1:0]      dx;
  logic [COORD_BITS-1:0]      dy;
  logic [COORD_BITS-1:0]      op;
  logic [SQ_W-1:0]            prod;
  logic [SQ_W-1:0]            acc;
  logic [CMP_W-1:0]           sum;

  // leader word is {y, x}
  assign diff_x = $signed({leader[COORD_BITS-1], leader[COORD_BITS-1:0]})
                - $signed({px[COORD_BITS-1], px});
  assign diff_y = $signed({leader[LEADER_W-1], leader[LEADER_W-1:COORD_BITS]})
                - $signed({py[COORD_BITS-1], py});
  assign abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
  assign abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;

  // shared squarer
  assign op = ctrl.sq_y ? dy : dx;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dx <= abs_x[COORD_BITS-1:0];
      dy <= abs_y[COORD_BITS-1:0];
    end
    if (ctrl.sq_x || ctrl.sq_y) begin
      prod <= SQ_W'(op) * SQ_W'(op);
    end
    if (ctrl.sq_y) begin
      acc <= prod;
    end
  end

  assign sum = CMP_W'(acc) + CMP_W'(prod);
  assign hit = sum < CMP_W'(radius);

endmodule
